// File: hw/rtl/bcf_pkg.sv
package bcf_pkg;

  localparam int MAX_ROWS       = 256;
  localparam int MAX_HALF_WIDTH = 16;
  localparam int ROW_W          = $clog2(MAX_ROWS);
  localparam int HW_W           = $clog2(MAX_HALF_WIDTH);
  localparam int BAND_DEPTH     = MAX_ROWS * MAX_HALF_WIDTH;
  localparam int BAND_AW        = ROW_W + HW_W;

  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;
  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PIVOT = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic CFG_MATRIX_SIZE = 1'b0;
  localparam logic CFG_HALF_WIDTH  = 1'b1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? INT64_MIN : INT64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? INT64_MIN : INT64_MAX;
    return s;
  endfunction

endpackage

// File: hw/rtl/bcf_cell.sv
module bcf_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic signed [31:0] shift_in,
  input  logic               load,
  input  logic signed [31:0] load_val,
  output logic signed [31:0] value
);

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_val;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

// File: hw/rtl/bcf_div.sv
module bcf_div import bcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic        [31:0] quo
);

  logic [63:0] mag;
  logic [31:0] rem;
  logic        neg;
  logic        active;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, mag[63]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        neg    <= num[63];
        mag    <= num[63] ? 64'(-num) : 64'(num);
      end else if (active) begin
        rem <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
        mag <= {mag[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (mag[63:32] != '0 || (mag[31] && mag[30:0] != '0)) quo = INT32_MIN;
      else quo = 32'(-mag[31:0]);
    end else begin
      if (mag[63:31] != '0) quo = INT32_MAX;
      else quo = mag[31:0];
    end
  end

endmodule

// File: hw/rtl/bcf_sqrt.sv
module bcf_sqrt import bcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] xr;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        active;
  logic [4:0]  cnt;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        xr     <= x;
        res    <= '0;
        bitv   <= 64'h4000_0000_0000_0000;
      end else if (active) begin
        if (xr >= trial) begin
          xr  <= xr - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign root = (res[63:31] != '0) ? INT32_MAX : res[31:0];

endmodule

// File: hw/rtl/banded_cholesky_factorizer.sv
// Write word: result in the cycle after acceptance; one write word per cycle
//   while the output is free. Read word: the store read is registered, then
//   S_READ gives the result when the output is free; no new word is taken meanwhile.
// Run word: each row passes the cell row, the 64-step divider and the 32-step square
//   root; a row whose pivot is not positive ends the run early.
// Reset: the size and half width registers return to 1; a clearing pass over all
//   4096 band entries zeroes both stores while no word is accepted.
module banded_cholesky_factorizer import bcf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [ROW_W-1:0]    row_index,
  input  logic [HW_W-1:0]     band_column,
  input  logic                is_diagonal,
  input  logic signed [31:0]  write_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  read_value,
  output logic [1:0]          status,
  output logic [ROW_W-1:0]    failed_row,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_PSTART, S_DOT, S_DIV, S_WB,
    S_SQ, S_RAD, S_CHK, S_SQRT, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [8:0] matrix_size;
  logic [4:0] band_half_width;
  logic [8:0] n_eff;
  logic [4:0] w_eff;

  logic signed [31:0] band_mem [0:BAND_DEPTH-1];
  logic signed [31:0] diag_mem [0:MAX_ROWS-1];

  logic               bm_we, bm_re;
  logic [BAND_AW-1:0] bm_wa, bm_ra;
  logic signed [31:0] bm_wd, band_q;
  logic               dm_we, dm_re;
  logic [ROW_W-1:0]   dm_wa, dm_ra;
  logic signed [31:0] dm_wd, diag_q;

  logic [BAND_AW-1:0] clr_cnt;
  logic [ROW_W-1:0]   ri;
  logic [HW_W-1:0]    pp;
  logic [4:0]         kk;
  logic               rd_diag, rd_zero, fail, ld_m;
  logic signed [63:0] acc, prod, num, rad;
  logic signed [31:0] a_d, e_q, qv, droot;
  logic               v1, v2;
  logic               div_start, sqrt_start;
  logic               div_done, sqrt_done;
  logic [31:0]        div_quo, sqrt_root;

  logic signed [31:0] cells [0:MAX_HALF_WIDTH-1];
  logic signed [31:0] ring_in;
  logic               ring_shift;

  logic               accept, out_free;
  logic [8:0]         i_plus_p;
  logic               skip_p, last_p, issue;
  logic [ROW_W-1:0]   jj;
  logic [HW_W-1:0]    kpos;
  logic               ld_ok;
  logic               in_row_ok, in_col_ok, in_inside;

  always_comb begin
    if (matrix_size == '0) n_eff = 9'd1;
    else if (matrix_size > 9'(MAX_ROWS)) n_eff = 9'(MAX_ROWS);
    else n_eff = matrix_size;
    if (band_half_width == '0) w_eff = 5'd1;
    else if (band_half_width > 5'(MAX_HALF_WIDTH)) w_eff = 5'(MAX_HALF_WIDTH);
    else w_eff = band_half_width;
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign in_row_ok = {1'b0, row_index} < n_eff;
  assign in_col_ok = is_diagonal || ({1'b0, band_column} < w_eff);
  assign in_inside = ({1'b0, row_index} + 9'(band_column)) >= 9'(w_eff);

  assign i_plus_p = {1'b0, ri} + 9'(pp);
  assign skip_p   = i_plus_p < 9'(w_eff);
  assign last_p   = (5'(pp) + 5'd1) == w_eff;
  assign jj       = 8'(i_plus_p - 9'(w_eff));
  assign kpos     = 4'(6'(kk) + 6'(w_eff) - 6'(pp));
  assign ld_ok    = (kk < w_eff) && (({1'b0, ri} + 9'(kk)) >= 9'(w_eff));
  assign issue    = (state == S_DOT || state == S_SQ) && kk < 5'(MAX_HALF_WIDTH);

  assign ring_shift = (state == S_LOAD && kk != '0) || issue;
  assign ring_in    = (state == S_LOAD) ? (ld_m ? band_q : 32'sd0) : cells[0];

  for (genvar t = 0; t < MAX_HALF_WIDTH; t++) begin : g_cell
    logic signed [31:0] nb;
    if (t == MAX_HALF_WIDTH - 1) begin : g_tail
      assign nb = ring_in;
    end else begin : g_mid
      assign nb = cells[t+1];
    end
    bcf_cell u_cell (
      .clk      (clk),
      .shift    (ring_shift),
      .shift_in (nb),
      .load     (state == S_WB && pp == HW_W'(t)),
      .load_val (qv),
      .value    (cells[t])
    );
  end

  bcf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (diag_q),
    .done  (div_done),
    .quo   (div_quo)
  );

  bcf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    bm_we = 1'b0;
    bm_wa = {ri, pp};
    bm_wd = qv;
    dm_we = 1'b0;
    dm_wa = ri;
    dm_wd = droot;
    bm_re = 1'b0;
    bm_ra = {row_index, band_column};
    dm_re = 1'b0;
    dm_ra = row_index;
    unique case (state)
      S_CLEAR: begin
        bm_we = 1'b1;
        bm_wa = clr_cnt;
        bm_wd = '0;
        dm_we = clr_cnt[BAND_AW-1:ROW_W] == '0;
        dm_wa = clr_cnt[ROW_W-1:0];
        dm_wd = '0;
      end
      S_IDLE: begin
        if (accept && in_row_ok && in_col_ok) begin
          if (req_type == REQ_WRITE) begin
            bm_we = !is_diagonal && in_inside;
            bm_wa = {row_index, band_column};
            bm_wd = write_value;
            dm_we = is_diagonal;
            dm_wa = row_index;
            dm_wd = write_value;
          end
          if (req_type == REQ_READ) begin
            bm_re = 1'b1;
            dm_re = 1'b1;
          end
        end
      end
      S_LOAD: begin
        bm_re = kk < 5'(MAX_HALF_WIDTH);
        bm_ra = {ri, kk[HW_W-1:0]};
      end
      S_PSTART: begin
        dm_re = 1'b1;
        dm_ra = jj;
      end
      S_DOT: begin
        bm_re = issue;
        bm_ra = {jj, kpos};
      end
      S_WB: bm_we = 1'b1;
      S_SQ: begin
        dm_re = 1'b1;
        dm_ra = ri;
      end
      S_FIN: dm_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) band_mem[bm_wa] <= bm_wd;
    if (bm_re) band_q <= band_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (dm_we) diag_mem[dm_wa] <= dm_wd;
    if (dm_re) diag_q <= diag_mem[dm_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_cnt         <= '0;
      matrix_size     <= 9'd1;
      band_half_width <= 5'd1;
      out_valid       <= 1'b0;
      div_start       <= 1'b0;
      sqrt_start      <= 1'b0;
      v1              <= 1'b0;
      v2              <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == CFG_MATRIX_SIZE) matrix_size <= cfg_data;
        if (cfg_index == CFG_HALF_WIDTH) band_half_width <= cfg_data[4:0];
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;

      v1 <= issue && (state == S_SQ || kk < 5'(pp));
      v2 <= v1;
      if (issue) a_d <= cells[0];
      if (issue && state == S_DOT && kk[HW_W-1:0] == pp) e_q <= cells[0];
      if (v1) prod <= a_d * ((state == S_SQ) ? a_d : band_q);
      if (v2) acc <= sat_add64(acc, prod);

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BAND_AW'(BAND_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            read_value <= '0;
            failed_row <= '0;
            status     <= STAT_OK;
            unique case (req_t'(req_type))
              REQ_WRITE: begin
                out_valid <= 1'b1;
                if (!(in_row_ok && in_col_ok)) status <= STAT_RANGE;
              end
              REQ_READ: begin
                if (!(in_row_ok && in_col_ok)) begin
                  out_valid <= 1'b1;
                  status    <= STAT_RANGE;
                end else begin
                  rd_diag <= is_diagonal;
                  rd_zero <= !is_diagonal && !in_inside;
                  state   <= S_READ;
                end
              end
              REQ_RUN: begin
                ri    <= '0;
                kk    <= '0;
                fail  <= 1'b0;
                state <= S_LOAD;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_value <= rd_zero ? 32'sd0 : (rd_diag ? diag_q : band_q);
            state      <= S_IDLE;
          end
        end
        S_LOAD: begin
          ld_m <= ld_ok;
          kk   <= kk + 5'd1;
          if (kk == 5'(MAX_HALF_WIDTH)) begin
            pp    <= '0;
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          kk  <= '0;
          acc <= '0;
          if (!skip_p) state <= S_DOT;
          else if (last_p) state <= S_SQ;
          else pp <= pp + 1'b1;
        end
        S_DOT: begin
          kk <= kk + 5'd1;
          if (kk == 5'(MAX_HALF_WIDTH + 2)) begin
            num <= sat_sub64({{16{e_q[31]}}, e_q, 16'h0000}, acc);
            if (diag_q > 32'sd0) begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end else begin
              qv    <= '0;
              state <= S_WB;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            qv    <= div_quo;
            state <= S_WB;
          end
        end
        S_WB: begin
          kk  <= '0;
          acc <= '0;
          if (last_p) begin
            state <= S_SQ;
          end else begin
            pp    <= pp + 1'b1;
            state <= S_PSTART;
          end
        end
        S_SQ: begin
          kk <= kk + 5'd1;
          if (kk == 5'(MAX_HALF_WIDTH + 2)) state <= S_RAD;
        end
        S_RAD: begin
          rad   <= sat_sub64({{16{diag_q[31]}}, diag_q, 16'h0000}, acc);
          state <= S_CHK;
        end
        S_CHK: begin
          if (rad[63] || rad == '0) begin
            fail  <= 1'b1;
            state <= S_OUT;
          end else begin
            sqrt_start <= 1'b1;
            state      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            droot <= sqrt_root;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if ({1'b0, ri} == n_eff - 9'd1) begin
            state <= S_OUT;
          end else begin
            ri    <= ri + 1'b1;
            kk    <= '0;
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_value <= '0;
            status     <= fail ? STAT_PIVOT : STAT_OK;
            failed_row <= fail ? ri : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sim/banded_cholesky_factorizer_test.sv
`timescale 1ns / 1ps

module banded_cholesky_factorizer_test;
  import bcf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         stat;
    logic [ROW_W-1:0]   row;
  } reply_t;

  typedef struct {
    logic [1:0]         req;
    logic [ROW_W-1:0]   row;
    logic [HW_W-1:0]    col;
    logic               diag;
    logic signed [31:0] value;
    bit                 typed;
    reply_t             want;
  } dir_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [ROW_W-1:0] row_index = '0;
  logic [HW_W-1:0] band_column = '0;
  logic is_diagonal = 1'b0;
  logic signed [31:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] read_value;
  logic [1:0] status;
  logic [ROW_W-1:0] failed_row;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  banded_cholesky_factorizer dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [31:0] band_mem [BAND_DEPTH];
  logic signed [31:0] diag_mem [MAX_ROWS];
  logic [8:0] size_reg;
  logic [4:0] width_reg;
  reply_t pending_replies[$];
  int errors = 0;
  int words_sent = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  int out_hold = 0;

  function automatic int rows_used();
    if (size_reg < 1) return 1;
    if (size_reg > MAX_ROWS) return MAX_ROWS;
    return size_reg;
  endfunction

  function automatic int band_used();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_HALF_WIDTH) return MAX_HALF_WIDTH;
    return width_reg;
  endfunction

  function automatic longint clamp_sum(logic signed [64:0] t);
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(t);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return INT32_MAX;
    if (v < -64'sh8000_0000) return INT32_MIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // returns the stopping row, or -1 when every pivot is positive
  function automatic int factor_band();
    int n, w, j;
    longint acc, num, q, rad;
    longint unsigned r;
    n = rows_used();
    w = band_used();
    for (int i = 0; i < n; i++) begin
      for (int p = 0; p < w; p++) begin
        if (i + p < w) continue;
        j = i - w + p;
        acc = 0;
        for (int k = 0; k < p; k++) begin
          if (i + k < w) continue;
          acc = clamp_sum(65'(acc) + 65'(longint'(band_mem[i*MAX_HALF_WIDTH+k]) *
                longint'(band_mem[j*MAX_HALF_WIDTH+k+w-p])));
        end
        num = clamp_sum(65'(longint'(band_mem[i*MAX_HALF_WIDTH+p]) * 65536) - 65'(acc));
        q = (diag_mem[j] > 0) ? num / longint'(diag_mem[j]) : 0;
        band_mem[i*MAX_HALF_WIDTH+p] = clamp32(q);
      end
      acc = 0;
      for (int p = 0; p < w; p++) begin
        if (i + p < w) continue;
        acc = clamp_sum(65'(acc) + 65'(longint'(band_mem[i*MAX_HALF_WIDTH+p]) *
              longint'(band_mem[i*MAX_HALF_WIDTH+p])));
      end
      rad = clamp_sum(65'(longint'(diag_mem[i]) * 65536) - 65'(acc));
      if (rad <= 0) return i;
      r = root64(longint'(rad));
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      diag_mem[i] = r[31:0];
    end
    return -1;
  endfunction

  function automatic reply_t predict_word(logic [1:0] req, int row, int col, bit diag,
                                          logic signed [31:0] value);
    reply_t rp;
    int f;
    rp = '0;
    if (req == REQ_RUN) begin
      f = factor_band();
      if (f >= 0) begin
        rp.stat = STAT_PIVOT;
        rp.row = f[ROW_W-1:0];
      end
    end else if (req == REQ_WRITE || req == REQ_READ) begin
      if (row >= rows_used() || (!diag && col >= band_used())) begin
        rp.stat = STAT_RANGE;
      end else if (diag) begin
        if (req == REQ_WRITE) diag_mem[row] = value;
        else rp.value = diag_mem[row];
      end else if (row + col >= band_used()) begin
        if (req == REQ_WRITE) band_mem[row*MAX_HALF_WIDTH+col] = value;
        else rp.value = band_mem[row*MAX_HALF_WIDTH+col];
      end
    end
    return rp;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [1:0] req, int row, int col, bit diag,
                           logic signed [31:0] value, bit typed = 0, reply_t want = '0);
    reply_t rp;
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    row_index <= row[ROW_W-1:0];
    band_column <= col[HW_W-1:0];
    is_diagonal <= diag;
    write_value <= value;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    rp = predict_word(req, row, col, diag, value);
    pending_replies.push_back(typed ? want : rp);
    words_sent++;
  endtask

  task automatic set_reg(logic idx, int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_MATRIX_SIZE) size_reg = value[8:0];
    else width_reg = value[4:0];
  endtask

  task automatic noise_words(int count);
    for (int k = 0; k < count; k++)
      send_word(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 15),
                1'($urandom_range(0, 1)), $urandom());
  endtask

  // load a diagonally dominant band (now and then with a negative diagonal), run, read back
  task automatic spd_phase(bit full_read);
    int n, w;
    logic signed [31:0] d;
    n = rows_used();
    w = band_used();
    for (int i = 0; i < n; i++) begin
      d = $urandom_range((2 * w + 2) << 16, 60 << 16);
      if ($urandom_range(0, 29) == 0) d = -$signed({1'b0, $urandom_range(0, 1 << 16)});
      send_word(REQ_WRITE, i, 0, 1, d);
      for (int p = 0; p < w; p++)
        if (i + p >= w || $urandom_range(0, 3) == 0)
          send_word(REQ_WRITE, i, p, 0, $signed($urandom_range(0, 2 << 16)) - (1 << 16));
    end
    if ($urandom_range(0, 3) == 0) noise_words($urandom_range(1, 4));
    send_word(REQ_RUN, 0, 0, 0, 0);
    for (int k = 0; k < (full_read ? n * (w + 1) : 2 * n + 2); k++)
      send_word(REQ_READ, $urandom_range(0, n - 1), $urandom_range(0, w - 1),
                $urandom_range(0, 3) == 0, 0);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20_000_000) begin
      $display("** banded_cholesky_factorizer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 7) == 0)
        out_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(negedge clk) begin
    reply_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{read_value, status, failed_row};
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: value %h status %0d row %0d",
                                   got.value, got.stat, got.row);
      end else begin
        want = pending_replies.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want value %h status %0d row %0d, got %h %0d %0d",
                     want.value, want.stat, want.row, got.value, got.stat, got.row);
        end
      end
    end
  end

  dir_word_t dir_tab[16];

  initial begin
    int phase;
    for (int k = 0; k < BAND_DEPTH; k++) band_mem[k] = '0;
    for (int k = 0; k < MAX_ROWS; k++) diag_mem[k] = '0;
    size_reg = 9'd1;
    width_reg = 5'd1;
    dir_tab = '{
      '{REQ_READ,   0,  0, 1, 0,           1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_WRITE,  0,  0, 1, INT32_MAX,   1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_READ,   0,  0, 1, 0,           1, '{INT32_MAX, STAT_OK, 8'd0}},
      '{REQ_WRITE,  0,  0, 0, -1,          1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_READ,   0,  0, 0, 0,           1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_WRITE,  1,  0, 1, 5,           1, '{32'sd0, STAT_RANGE, 8'd0}},
      '{REQ_WRITE,  255, 0, 0, 5,          1, '{32'sd0, STAT_RANGE, 8'd0}},
      '{REQ_READ,   0,  15, 0, 0,          1, '{32'sd0, STAT_RANGE, 8'd0}},
      '{REQ_READ,   0,  1, 0, 0,           1, '{32'sd0, STAT_RANGE, 8'd0}},
      '{REQ_UNUSED, 255, 15, 1, -1,        1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_RUN,    0,  0, 0, 0,           0, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_READ,   0,  0, 1, 0,           0, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_WRITE,  0,  0, 1, INT32_MIN,   1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_RUN,    0,  0, 0, 0,           1, '{32'sd0, STAT_PIVOT, 8'd0}},
      '{REQ_WRITE,  0,  0, 1, 0,           1, '{32'sd0, STAT_OK, 8'd0}},
      '{REQ_RUN,    0,  0, 0, 0,           1, '{32'sd0, STAT_PIVOT, 8'd0}}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    calm = 1'b1;
    foreach (dir_tab[k])
      send_word(dir_tab[k].req, dir_tab[k].row, dir_tab[k].col, dir_tab[k].diag,
                dir_tab[k].value, dir_tab[k].typed, dir_tab[k].want);
    phase = 0;
    while (words_sent < 1850) begin
      calm = ($urandom_range(0, 4) == 0);
      case (phase)
        0: begin
          set_reg(CFG_MATRIX_SIZE, 0);
          set_reg(CFG_HALF_WIDTH, 0);
          spd_phase(1);
        end
        1: begin
          set_reg(CFG_MATRIX_SIZE, 511);
          set_reg(CFG_HALF_WIDTH, 31);
          send_word(REQ_WRITE, 0, 0, 1, 0);
          noise_words(30);
          send_word(REQ_WRITE, 0, 0, 1, -7);
          send_word(REQ_RUN, 0, 0, 0, 0);
        end
        2: begin
          set_reg(CFG_MATRIX_SIZE, 256);
          set_reg(CFG_HALF_WIDTH, 1);
          spd_phase(0);
        end
        3: begin
          set_reg(CFG_MATRIX_SIZE, 3);
          set_reg(CFG_HALF_WIDTH, 16);
          spd_phase(1);
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            set_reg(CFG_MATRIX_SIZE, $urandom_range(9, 40));
            set_reg(CFG_HALF_WIDTH, $urandom_range(5, 16));
          end else begin
            set_reg(CFG_MATRIX_SIZE, $urandom_range(1, 8));
            set_reg(CFG_HALF_WIDTH, $urandom_range(1, 4));
          end
          spd_phase($urandom_range(0, 1));
          noise_words($urandom_range(2, 10));
        end
      endcase
      phase++;
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** banded_cholesky_factorizer: PASSED **");
    end else begin
      $display("** banded_cholesky_factorizer: FAILED **");
    end
    $finish;
  end

endmodule
